@@ src/mtp_pkg.sv @@
// ----------------------------------------------------------------------------
// Timer pool package
// Shared sizes, command codes, item types and control structs of the pool.
// ----------------------------------------------------------------------------
package mtp_pkg;

  // Pool size and counter width.
  localparam int NUM_TIMERS = 8;
  localparam int COUNT_BITS = 16;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  // Field widths of the channel items.
  localparam int CMD_W    = 2;
  localparam int PERIOD_W = 16;
  localparam int REPEAT_W = 8;
  localparam int ID_W     = 4;
  localparam int MASK_W   = 8;
  localparam int DONE_W   = REPEAT_W + 1;

  // Code returned when no timer is granted, masked to the id field.
  localparam logic [ID_W-1:0] NO_TIMER = ID_W'(NUM_TIMERS);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CREATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [PERIOD_W-1:0] period;
    logic [REPEAT_W-1:0] repeat_count;
    logic                repeat_forever;
    logic [ID_W-1:0]     timer_id;
  } cmd_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   granted_id;
    logic              ok;
    logic [MASK_W-1:0] fired_mask;
  } rsp_item_t;

  // Operation applied by the slot unit to the selected timer.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_TICK,
    OP_CREATE,
    OP_CANCEL,
    OP_CHECK
  } slot_op_e;

  typedef struct packed {
    slot_op_e            op;
    logic [IDX_W-1:0]    idx;
    logic [PERIOD_W-1:0] period;
    logic [REPEAT_W-1:0] repeat_count;
    logic                repeat_forever;
  } slot_cmd_t;

  typedef struct packed {
    logic active;
    logic flag;
    logic fire;
  } slot_sts_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_CREATE,
    S_CANCEL,
    S_CHECK,
    S_DONE
  } seq_state_e;

endpackage

@@ src/mtp_if.sv @@
// ----------------------------------------------------------------------------
// Timer pool channels
// Valid/ready channels for command items and response items.
// ----------------------------------------------------------------------------
interface mtp_cmd_if;
  logic              valid;
  logic              ready;
  mtp_pkg::cmd_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mtp_rsp_if;
  logic              valid;
  logic              ready;
  mtp_pkg::rsp_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/multi_timer_pool_core.sv @@
// ----------------------------------------------------------------------------
// Timer pool core
// A pool of timers driven by tick, create, cancel and check command items.
//
//   Channel  Direction  Item                                         Handshake
//   cmd_i    in         command, period, repeat_count, forever, id   valid/ready
//   rsp_o    out        granted_id, ok, fired_mask                   valid/ready
//
// A tick walks every timer through the single timer update unit, which
// visits one timer per cycle, before its result goes to the result register.
// A create searches for the lowest free timer; cancel and check act on the
// timer that the item names, if in range. One item is in work at a time, and
// the block is ready again in the cycle after the result register is loaded.
// Reset clears every timer at once; the block takes items right after reset.
// A stalled result stays in the output register; the block finishes the next
// item and holds it until the register is free.
// ----------------------------------------------------------------------------
module multi_timer_pool_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  mtp_cmd_if.sink   cmd_i,
  mtp_rsp_if.source rsp_o
);

  mtp_pkg::slot_cmd_t slot_cmd;
  mtp_pkg::slot_sts_t slot_sts;
  mtp_pkg::rsp_item_t res;
  logic               res_push, out_free;
  logic               rsp_valid_q, rsp_valid_d;
  mtp_pkg::rsp_item_t rsp_data_q;

  mtp_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_i.ready),
    .cmd_data_i  (cmd_i.data),
    .out_free_i  (out_free),
    .res_push_o  (res_push),
    .res_o       (res),
    .slot_cmd_o  (slot_cmd),
    .slot_sts_i  (slot_sts)
  );

  mtp_slot_unit u_slot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (slot_cmd),
    .sts_o  (slot_sts)
  );

  // Output register.
  assign out_free = !rsp_valid_q || rsp_o.ready;

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (res_push) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      rsp_data_q <= res;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_data_q;

endmodule

@@ src/mtp_slot_unit.sv @@
// ----------------------------------------------------------------------------
// Timer pool slot unit
// Holds the per-timer state and applies one operation to one timer a cycle.
// ----------------------------------------------------------------------------
module mtp_slot_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mtp_pkg::slot_cmd_t cmd_i,
  output mtp_pkg::slot_sts_t sts_o
);

  logic [mtp_pkg::NUM_TIMERS-1:0]                           active_q, active_d;
  logic [mtp_pkg::NUM_TIMERS-1:0]                           flag_q, flag_d;
  logic [mtp_pkg::NUM_TIMERS-1:0]                           forever_q;
  logic [mtp_pkg::NUM_TIMERS-1:0][mtp_pkg::COUNT_BITS-1:0]  period_q;
  logic [mtp_pkg::NUM_TIMERS-1:0][mtp_pkg::COUNT_BITS-1:0]  count_q;
  logic [mtp_pkg::NUM_TIMERS-1:0][mtp_pkg::REPEAT_W-1:0]    total_q;
  logic [mtp_pkg::NUM_TIMERS-1:0][mtp_pkg::DONE_W-1:0]      done_q;

  logic                           sel_active, sel_flag, sel_forever;
  logic [mtp_pkg::COUNT_BITS-1:0] sel_period, sel_count, count_d;
  logic [mtp_pkg::REPEAT_W-1:0]   sel_total;
  logic [mtp_pkg::DONE_W-1:0]     sel_done, done_d;
  logic                           active_n, flag_n, fire;
  logic                           wr_count, wr_load;

  // Read the selected timer.
  assign sel_active  = active_q[cmd_i.idx];
  assign sel_flag    = flag_q[cmd_i.idx];
  assign sel_forever = forever_q[cmd_i.idx];
  assign sel_period  = period_q[cmd_i.idx];
  assign sel_count   = count_q[cmd_i.idx];
  assign sel_total   = total_q[cmd_i.idx];
  assign sel_done    = done_q[cmd_i.idx];

  // Shared update unit: the next state of the selected timer.
  always_comb begin
    active_n = sel_active;
    flag_n   = sel_flag;
    count_d  = sel_count;
    done_d   = sel_done;
    fire     = 1'b0;
    wr_count = 1'b0;
    wr_load  = 1'b0;
    case (cmd_i.op)
      mtp_pkg::OP_TICK: begin
        if (sel_active) begin
          wr_count = 1'b1;
          if (sel_count != sel_period) begin
            count_d = sel_count + 1'b1;
          end else begin
            count_d = '0;
            if (sel_forever) begin
              fire = 1'b1;
            end else begin
              done_d = sel_done + 1'b1;
              if (done_d <= {1'b0, sel_total}) begin
                fire = 1'b1;
              end else begin
                // Expired: deactivate but keep the timeout flag.
                active_n = 1'b0;
              end
            end
            if (fire) begin
              flag_n = 1'b1;
            end
          end
        end
      end
      mtp_pkg::OP_CREATE: begin
        if (!sel_active) begin
          wr_load  = 1'b1;
          active_n = 1'b1;
          flag_n   = 1'b0;
        end
      end
      mtp_pkg::OP_CANCEL: begin
        active_n = 1'b0;
        flag_n   = 1'b0;
      end
      mtp_pkg::OP_CHECK: begin
        flag_n = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Write the control bits back.
  always_comb begin
    active_d = active_q;
    flag_d   = flag_q;
    active_d[cmd_i.idx] = active_n;
    flag_d[cmd_i.idx]   = flag_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      flag_q   <= '0;
    end else begin
      active_q <= active_d;
      flag_q   <= flag_d;
    end
  end

  // Payload fields; only read while the timer is active.
  always_ff @(posedge clk_i) begin
    if (wr_count) begin
      count_q[cmd_i.idx] <= count_d;
      done_q[cmd_i.idx]  <= done_d;
    end
    if (wr_load) begin
      count_q[cmd_i.idx]   <= '0;
      done_q[cmd_i.idx]    <= '0;
      period_q[cmd_i.idx]  <= mtp_pkg::COUNT_BITS'(cmd_i.period);
      total_q[cmd_i.idx]   <= (cmd_i.repeat_count == '0) ? mtp_pkg::REPEAT_W'(1)
                                                         : cmd_i.repeat_count;
      forever_q[cmd_i.idx] <= cmd_i.repeat_forever;
    end
  end

  assign sts_o.active = sel_active;
  assign sts_o.flag   = sel_flag;
  assign sts_o.fire   = fire;

endmodule

@@ src/mtp_sequencer.sv @@
// ----------------------------------------------------------------------------
// Timer pool sequencer
// Takes a command item, walks the slot unit over the timers and builds the
// response item.
// ----------------------------------------------------------------------------
module mtp_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  mtp_pkg::cmd_item_t cmd_data_i,
  input  logic               out_free_i,
  output logic               res_push_o,
  output mtp_pkg::rsp_item_t res_o,
  output mtp_pkg::slot_cmd_t slot_cmd_o,
  input  mtp_pkg::slot_sts_t slot_sts_i
);

  mtp_pkg::seq_state_e               state_q, state_d;
  logic [mtp_pkg::IDX_W-1:0]         idx_q, idx_d;
  mtp_pkg::cmd_item_t                item_q;
  logic                              id_ok_q;
  logic [mtp_pkg::ID_W-1:0]          grant_q, grant_d;
  logic                              ok_q, ok_d;
  logic [mtp_pkg::MASK_W-1:0]        fired_q, fired_d;
  logic                              accept, last;

  assign accept = cmd_valid_i && cmd_ready_o;
  assign last   = (idx_q == mtp_pkg::IDX_W'(mtp_pkg::NUM_TIMERS - 1));

  // State register and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mtp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    grant_q <= grant_d;
    ok_q    <= ok_d;
    fired_q <= fired_d;
    if (accept) begin
      item_q  <= cmd_data_i;
      id_ok_q <= (32'(cmd_data_i.timer_id) < mtp_pkg::NUM_TIMERS);
    end
  end

  // Next state, slot operation and result.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    grant_d     = grant_q;
    ok_d        = ok_q;
    fired_d     = fired_q;
    cmd_ready_o = 1'b0;
    res_push_o  = 1'b0;

    slot_cmd_o.op             = mtp_pkg::OP_NONE;
    slot_cmd_o.idx            = idx_q;
    slot_cmd_o.period         = item_q.period;
    slot_cmd_o.repeat_count   = item_q.repeat_count;
    slot_cmd_o.repeat_forever = item_q.repeat_forever;

    case (state_q)
      mtp_pkg::S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          grant_d = mtp_pkg::NO_TIMER;
          ok_d    = 1'b0;
          fired_d = '0;
          case (cmd_data_i.command)
            mtp_pkg::CMD_TICK: begin
              idx_d   = '0;
              state_d = mtp_pkg::S_TICK;
            end
            mtp_pkg::CMD_CREATE: begin
              idx_d   = '0;
              state_d = mtp_pkg::S_CREATE;
            end
            mtp_pkg::CMD_CANCEL: begin
              idx_d   = mtp_pkg::IDX_W'(cmd_data_i.timer_id);
              state_d = mtp_pkg::S_CANCEL;
            end
            default: begin
              idx_d   = mtp_pkg::IDX_W'(cmd_data_i.timer_id);
              state_d = mtp_pkg::S_CHECK;
            end
          endcase
        end
      end
      mtp_pkg::S_TICK: begin
        // One timer per cycle; only timers 0 to 7 reach the mask.
        slot_cmd_o.op = mtp_pkg::OP_TICK;
        for (int k = 0; k < mtp_pkg::MASK_W; k++) begin
          if (slot_sts_i.fire && (32'(idx_q) == k)) begin
            fired_d[k] = 1'b1;
          end
        end
        if (last) begin
          state_d = mtp_pkg::S_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      mtp_pkg::S_CREATE: begin
        // Claim the lowest inactive timer.
        slot_cmd_o.op = mtp_pkg::OP_CREATE;
        if (!slot_sts_i.active) begin
          grant_d = mtp_pkg::ID_W'(idx_q);
          ok_d    = 1'b1;
          state_d = mtp_pkg::S_DONE;
        end else if (last) begin
          state_d = mtp_pkg::S_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      mtp_pkg::S_CANCEL: begin
        if (id_ok_q) begin
          slot_cmd_o.op = mtp_pkg::OP_CANCEL;
          ok_d          = 1'b1;
        end
        state_d = mtp_pkg::S_DONE;
      end
      mtp_pkg::S_CHECK: begin
        if (id_ok_q) begin
          slot_cmd_o.op = mtp_pkg::OP_CHECK;
          ok_d          = slot_sts_i.flag;
        end
        state_d = mtp_pkg::S_DONE;
      end
      mtp_pkg::S_DONE: begin
        // Hand the result over once the output register is free.
        if (out_free_i) begin
          res_push_o = 1'b1;
          state_d    = mtp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mtp_pkg::S_IDLE;
      end
    endcase
  end

  assign res_o.granted_id = grant_q;
  assign res_o.ok         = ok_q;
  assign res_o.fired_mask = fired_q;

endmodule

@@ src/mtp_checker.sv @@
// ----------------------------------------------------------------------------
// Timer pool checker
// Port-level properties of the timer pool core, bound to the top level.
// ----------------------------------------------------------------------------
module mtp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cmd_valid_i,
  input logic               cmd_ready_i,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input mtp_pkg::rsp_item_t rsp_data_i
);

  // A response waits until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  // An accepted item keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)
    else $error("block ready right after accepting an item");

  // A granted id always comes with ok.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_data_i.granted_id != mtp_pkg::NO_TIMER) |-> rsp_data_i.ok)
    else $error("timer granted without ok");

  // Only a tick reports fired timers, and a tick has no grant and no ok.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_data_i.fired_mask != '0)
      |-> (rsp_data_i.granted_id == mtp_pkg::NO_TIMER) && !rsp_data_i.ok)
    else $error("fired mask on a non-tick response");

endmodule

bind multi_timer_pool_core mtp_checker u_mtp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cmd_valid_i (cmd_i.valid),
  .cmd_ready_i (cmd_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);

@@ verif/mtp_response_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timer pool response checker
// Watches both channels of the timer pool, keeps its own model of every
// timer, works out the response to each accepted command item and compares
// every accepted response item with the oldest one still owed.
// ----------------------------------------------------------------------------
module mtp_response_checker
  import mtp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  mtp_cmd_if   cmd_i,
  mtp_rsp_if   rsp_i,
  output int   fail_count_o,
  output int   pending_o
);

  // Model state, one entry per timer.
  logic                  tmr_active  [NUM_TIMERS];
  logic [COUNT_BITS-1:0] tmr_period  [NUM_TIMERS];
  logic [COUNT_BITS-1:0] tmr_count   [NUM_TIMERS];
  logic [REPEAT_W-1:0]   tmr_total   [NUM_TIMERS];
  logic [DONE_W-1:0]     tmr_done    [NUM_TIMERS];
  logic                  tmr_endless [NUM_TIMERS];
  logic                  tmr_flag    [NUM_TIMERS];

  // Responses owed by the block, oldest first.
  rsp_item_t owed_rsp_q [$];
  int        mismatches;

  // Returns a timer to its idle state; an expiring timer keeps its flag.
  function automatic void clear_timer(int idx, bit keep_flag);
    tmr_active[idx]  = 1'b0;
    tmr_period[idx]  = '0;
    tmr_count[idx]   = '0;
    tmr_total[idx]   = '0;
    tmr_done[idx]    = '0;
    tmr_endless[idx] = 1'b0;
    if (!keep_flag) begin
      tmr_flag[idx] = 1'b0;
    end
  endfunction

  // Applies one command item to the model and returns the response it causes.
  function automatic rsp_item_t apply_command(cmd_item_t item);
    rsp_item_t rsp;
    bit        fire;
    rsp.granted_id = NO_TIMER;
    rsp.ok         = 1'b0;
    rsp.fired_mask = '0;
    case (item.command)
      CMD_TICK: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (tmr_active[i]) begin
            if (tmr_count[i] != tmr_period[i]) begin
              tmr_count[i] = tmr_count[i] + 1'b1;
            end else begin
              // The count has reached the period: restart and fire, unless a
              // counted timer has used up its firings, in which case it expires.
              tmr_count[i] = '0;
              fire = tmr_endless[i];
              if (!tmr_endless[i]) begin
                tmr_done[i] = tmr_done[i] + 1'b1;
                if (tmr_done[i] <= DONE_W'(tmr_total[i])) begin
                  fire = 1'b1;
                end else begin
                  clear_timer(i, 1'b1);
                end
              end
              if (fire) begin
                tmr_flag[i] = 1'b1;
                if (i < MASK_W) begin
                  rsp.fired_mask[i] = 1'b1;
                end
              end
            end
          end
        end
      end
      CMD_CREATE: begin
        // The lowest inactive timer is claimed.
        for (int i = 0; i < NUM_TIMERS && !rsp.ok; i++) begin
          if (!tmr_active[i]) begin
            tmr_count[i]   = '0;
            tmr_period[i]  = COUNT_BITS'(item.period);
            tmr_done[i]    = '0;
            tmr_total[i]   = (item.repeat_count == '0) ? REPEAT_W'(1) : item.repeat_count;
            tmr_endless[i] = item.repeat_forever;
            tmr_flag[i]    = 1'b0;
            tmr_active[i]  = 1'b1;
            rsp.granted_id = ID_W'(i);
            rsp.ok         = 1'b1;
          end
        end
      end
      CMD_CANCEL: begin
        if (item.timer_id < NUM_TIMERS) begin
          clear_timer(int'(item.timer_id), 1'b0);
          rsp.ok = 1'b1;
        end
      end
      default: begin
        if (item.timer_id < NUM_TIMERS && tmr_flag[item.timer_id]) begin
          tmr_flag[item.timer_id] = 1'b0;
          rsp.ok = 1'b1;
        end
      end
    endcase
    return rsp;
  endfunction

  // Responses are checked before the command of the same edge is modeled,
  // since a response always belongs to an earlier command.
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_item_t owed;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        clear_timer(i, 1'b0);
      end
      owed_rsp_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (owed_rsp_q.size() == 0) begin
          $error("response item arrived with no command item waiting for one");
          mismatches++;
        end else begin
          owed = owed_rsp_q.pop_front();
          if (rsp_i.data.granted_id !== owed.granted_id) begin
            $error("granted_id: expected %0d, actual %0d",
                   owed.granted_id, rsp_i.data.granted_id);
            mismatches++;
          end
          if (rsp_i.data.ok !== owed.ok) begin
            $error("ok: expected %0d, actual %0d", owed.ok, rsp_i.data.ok);
            mismatches++;
          end
          if (rsp_i.data.fired_mask !== owed.fired_mask) begin
            $error("fired_mask: expected 0x%02h, actual 0x%02h",
                   owed.fired_mask, rsp_i.data.fired_mask);
            mismatches++;
          end
        end
      end
      if (cmd_i.valid && cmd_i.ready) begin
        owed_rsp_q.push_back(apply_command(cmd_i.data));
      end
      fail_count_o <= mismatches;
      pending_o    <= owed_rsp_q.size();
    end
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timer pool testbench
// Sends a directed set of command items and then random command streams with
// random gaps, takes responses with random stalls and one long hold-off, and
// reports the verdict from the response checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_top;
  import mtp_pkg::*;

  localparam int RANDOM_ITEMS    = 1825;
  localparam int MAX_IDLE        = 19;
  localparam int HOLD_OFF_AT     = 600;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = NUM_TIMERS + 8;
  localparam int CMD_ITEM_W      = $bits(cmd_item_t);

  logic clk_i = 1'b0;
  logic rst_ni;
  logic no_idle;
  int   fail_count;
  int   pending_count;

  mtp_cmd_if cmd_ch ();
  mtp_rsp_if rsp_ch ();

  multi_timer_pool_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_ch),
    .rsp_o  (rsp_ch)
  );

  mtp_response_checker u_rsp_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_ch),
    .rsp_i        (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  // 2 ns clock.
  always #1 clk_i = ~clk_i;

  // Builds one command item from its fields.
  function automatic cmd_item_t make_cmd(logic [CMD_W-1:0] command,
                                         logic [PERIOD_W-1:0] period,
                                         logic [REPEAT_W-1:0] repeat_count,
                                         logic fev,
                                         logic [ID_W-1:0] timer_id);
    cmd_item_t item;
    item.command        = command;
    item.period         = period;
    item.repeat_count   = repeat_count;
    item.repeat_forever = fev;
    item.timer_id       = timer_id;
    return item;
  endfunction

  // Draws a random command item: mostly ticks, with short periods and small
  // repeat counts so that timers fire and expire often; a few items are noise.
  function automatic cmd_item_t random_cmd();
    cmd_item_t   item;
    int unsigned pick;
    int unsigned shape;
    item  = CMD_ITEM_W'($urandom);
    pick  = $urandom_range(0, 99);
    shape = $urandom_range(0, 19);
    if (pick < 3) begin
      return item;
    end else if (pick < 55) begin
      item.command = CMD_TICK;
    end else if (pick < 70) begin
      item.command = CMD_CREATE;
      if (shape < 14) begin
        item.period = PERIOD_W'($urandom_range(0, 6));
      end else if (shape < 18) begin
        item.period = PERIOD_W'($urandom_range(7, 40));
      end
      shape = $urandom_range(0, 19);
      if (shape < 15) begin
        item.repeat_count = REPEAT_W'($urandom_range(0, 4));
      end else if (shape < 18) begin
        item.repeat_count = REPEAT_W'($urandom_range(5, 20));
      end
      item.repeat_forever = ($urandom_range(0, 4) == 0);
    end else begin
      item.command = (pick < 82) ? CMD_CANCEL : CMD_CHECK;
      if (shape != 0) begin
        item.timer_id = ID_W'($urandom_range(0, NUM_TIMERS - 1));
      end
    end
    return item;
  endfunction

  // Offers one item after a random gap and returns once it is accepted.
  // Valid is only lowered when a gap follows, so it never drops and rises in
  // the same step.
  task automatic send_cmd(input cmd_item_t item);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= item;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
  endtask

  // Response side: random stalls per item, and one long hold-off so that the
  // block fills up and stalls its command channel.
  initial begin : response_sink
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    rsp_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (taken == HOLD_OFF_AT) begin
        stall = HOLD_OFF_CYCLES;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_ch.valid) @(posedge clk_i);
      taken++;
    end
  end

  // Reset, directed items, random items, drain and verdict.
  initial begin : stimulus
    cmd_ch.valid <= 1'b0;
    cmd_ch.data  <= '0;
    rst_ni       <= 1'b0;
    no_idle = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Checks and cancels on an empty pool, including ids out of range.
    send_cmd(make_cmd(CMD_CHECK, '0, '0, 1'b0, ID_W'(0)));
    send_cmd(make_cmd(CMD_CANCEL, '0, '0, 1'b0, '1));
    send_cmd(make_cmd(CMD_CHECK, '0, '0, 1'b0, NO_TIMER));
    send_cmd(make_cmd(CMD_CANCEL, '0, '0, 1'b0, ID_W'(3)));

    // Fill the pool: zero period with repeat count zero, longest period with
    // the largest count, endless timers, then one create with no timer free.
    send_cmd(make_cmd(CMD_CREATE, '0, '0, 1'b0, '0));
    send_cmd(make_cmd(CMD_CREATE, '1, '1, 1'b0, '0));
    send_cmd(make_cmd(CMD_CREATE, PERIOD_W'(2), '1, 1'b1, '1));
    send_cmd(make_cmd(CMD_CREATE, '0, REPEAT_W'(3), 1'b1, '0));
    send_cmd(make_cmd(CMD_CREATE, PERIOD_W'(1), REPEAT_W'(2), 1'b0, '0));
    repeat (3) send_cmd(make_cmd(CMD_CREATE, PERIOD_W'(3), REPEAT_W'(1), 1'b0, '0));
    send_cmd(make_cmd(CMD_CREATE, PERIOD_W'(4), REPEAT_W'(1), 1'b0, '0));

    // Ticks: timer 0 fires once and then expires, keeping its flag.
    repeat (6) send_cmd(make_cmd(CMD_TICK, '0, '0, 1'b0, '0));
    send_cmd(make_cmd(CMD_CHECK, '0, '0, 1'b0, ID_W'(0)));
    send_cmd(make_cmd(CMD_CHECK, '0, '0, 1'b0, ID_W'(0)));

    // Cancel an active timer, reuse the expired slot, cancel out of range, tick.
    send_cmd(make_cmd(CMD_CANCEL, '0, '0, 1'b0, ID_W'(1)));
    send_cmd(make_cmd(CMD_CREATE, PERIOD_W'(5), '0, 1'b0, '0));
    send_cmd(make_cmd(CMD_CANCEL, '1, '1, 1'b1, NO_TIMER));
    send_cmd(make_cmd(CMD_TICK, '1, '1, 1'b1, '1));

    // Random streams, with two stretches where neither side idles.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 500 && n < 700) || (n >= 1300 && n < 1400);
      send_cmd(random_cmd());
    end
    cmd_ch.valid <= 1'b0;
    no_idle = 1'b0;

    // Wait for every owed response, then drain to catch anything extra.
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("multi_timer_pool_core regression: pass");
    end else begin
      $display("multi_timer_pool_core regression: fail");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin : run_limit
    #1_000_000;
    $display("multi_timer_pool_core regression: fail");
    $finish;
  end

endmodule
